[sv/erf_normal_cdf_pdf_macros.svh]
// Assertion macros for the error function / normal distribution block.
`ifndef ERF_NORMAL_CDF_PDF_MACROS_SVH
`define ERF_NORMAL_CDF_PDF_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ECDF_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ecdf assertion failed");
`define ECDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ecdf assertion failed");
`else
`define ECDF_ASSERT_IMPL(label, clk, rst, ante, cons)
`define ECDF_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[sv/ecdf_pkg.sv]
// Shared types and Q60 constants for the erf / normal CDF / normal PDF pipeline.
package ecdf_pkg;

   typedef enum logic [1:0] {
      OP_ERF  = 2'd0,
      OP_CDF  = 2'd1,
      OP_PDF  = 2'd2,
      OP_ZERO = 2'd3
   } op_type;

   localparam logic [63:0] ONE60 = 64'd1 << 60;

   localparam logic [63:0] COEF_A1 = 64'((128'd254829592 << 60) / 128'd1000000000);
   localparam logic [63:0] COEF_A2 =
      64'd0 - 64'((128'd284496736 << 60) / 128'd1000000000);
   localparam logic [63:0] COEF_A3 = 64'((128'd1421413741 << 60) / 128'd1000000000);
   localparam logic [63:0] COEF_A4 =
      64'd0 - 64'((128'd1453152027 << 60) / 128'd1000000000);
   localparam logic [63:0] COEF_A5 = 64'((128'd1061405429 << 60) / 128'd1000000000);
   localparam logic [63:0] COEF_P = 64'((128'd3275911 << 60) / 128'd10000000);
   localparam logic [63:0] NORM_PDF_SCALE =
      64'((128'd3989422804 << 60) / 128'd10000000000);
   localparam logic [63:0] INV_SQRT2 =
      64'((128'd7071067812 << 60) / 128'd10000000000);

   // added after each Horner multiply; the last multiply adds nothing
   localparam logic [63:0] POLY_ADD [0:4] = '{COEF_A4, COEF_A3, COEF_A2, COEF_A1, 64'd0};

   // everything one sample carries down the chain
   typedef struct packed {
      op_type      op;
      logic        neg;
      logic        big;
      logic        sgn;
      logic [31:0] mag;
      logic [63:0] a;
      logic [63:0] dvs;
      logic [63:0] rem;
      logic [63:0] quo;
      logic [63:0] t;
      logic [63:0] w;
      logic [63:0] term;
      logic [63:0] tv;
      logic [63:0] sum;
      logic [63:0] e;
      logic [63:0] pdf;
      logic [63:0] acc;
   } item_type;

endpackage

[sv/ecdf_channels.sv]
// Valid/ready channel interfaces for request and response transactions.
interface ecdf_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        operation;
   logic signed [31:0] x_value;
   modport source (output valid, output operation, output x_value, input ready);
   modport sink (input valid, input operation, input x_value, output ready);
endinterface

interface ecdf_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] result_value;
   modport source (output valid, output result_value, input ready);
   modport sink (input valid, input result_value, output ready);
endinterface

[sv/erf_normal_cdf_pdf.sv]
// Top level: pipelined erf, standard normal CDF and standard normal PDF.
//
// One transaction in, one result out, fully pipelined: a new sample is taken
// every cycle unless the chain is held (see below). The pipeline depth is
// the length of the cell chain: the 61 one-bit cells of the reciprocal
// 1/(1+p*a), 24 Taylor cells of exp(-w) (each a term multiply
// and a reciprocal-multiply divide by the term index), six squaring cells,
// five Horner cells, and five-stage 64x64 multipliers: an input register, then
// one 32x32 partial product per stage. The whole chain advances together; it
// holds only while a finished result sits in the output register and is not taken.
// Operation 0 gives erf(x), 1 the normal CDF, 2 the normal PDF, 3 gives zero.
// x is Q(32-X_FRAC_BITS).X_FRAC_BITS, the result Q2.30 rounded half away from
// zero from 60 fraction bits; |x| >= 8 (erf) or >= 11 (CDF, PDF) returns the limit.
`include "erf_normal_cdf_pdf_macros.svh"
module erf_normal_cdf_pdf #(
   parameter int X_FRAC_BITS = 16
) (
   input logic        clock,
   input logic        reset,
   ecdf_req_if.sink   req_ch,
   ecdf_rsp_if.source rsp_ch
);
   localparam logic [31:0] LIMIT_ERF   = 32'd8 << X_FRAC_BITS;
   localparam logic [31:0] LIMIT_OTHER = 32'd11 << X_FRAC_BITS;
   localparam logic [31:0] ONE30       = 32'd1 << 30;

   logic out_valid_ff;
   logic adv;
   assign adv          = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = adv && !reset;

   function automatic logic [31:0] round30(input logic [63:0] v);
      logic [63:0] s;
      s = v + (64'd1 << 29);
      return s[61:30];
   endfunction

   // ---- input register: sign fold and range check
   logic               v_in_ff;
   ecdf_pkg::item_type item_in_ff, item_in;
   logic [31:0]        x_bits;

   always_comb begin
      x_bits       = req_ch.x_value;
      item_in      = '0;
      item_in.op   = ecdf_pkg::op_type'(req_ch.operation);
      item_in.neg  = x_bits[31];
      item_in.mag  = x_bits[31] ? 32'd0 - x_bits : x_bits;
      item_in.big  = item_in.mag >= ((item_in.op == ecdf_pkg::OP_ERF) ? LIMIT_ERF
                                                                     : LIMIT_OTHER);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_in_ff <= 1'b0;
      end else if (adv) begin
         v_in_ff <= req_ch.valid && req_ch.ready;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_in_ff <= item_in;
      end
   end

   // ---- a = |x| (erf) or |x|/sqrt2 (CDF, PDF), Q60
   logic               a_valid;
   logic [127:0]       a_prod;
   ecdf_pkg::item_type a_item, item_a;

   ecdf_mul u_mul_a (
      .clock, .reset, .adv,
      .in_valid (v_in_ff), .in_x ({32'd0, item_in_ff.mag}), .in_y (ecdf_pkg::INV_SQRT2),
      .in_item (item_in_ff),
      .out_valid (a_valid), .out_prod (a_prod), .out_item (a_item)
   );

   always_comb begin
      item_a   = a_item;
      item_a.a = (a_item.op == ecdf_pkg::OP_ERF) ? {32'd0, a_item.mag} << (60 - X_FRAC_BITS)
                                                 : a_prod[X_FRAC_BITS +: 64];
   end

   // ---- divisor d = 1 + p*a
   logic               p_valid;
   logic [127:0]       p_prod;
   ecdf_pkg::item_type p_item;

   ecdf_mul u_mul_p (
      .clock, .reset, .adv,
      .in_valid (a_valid), .in_x (ecdf_pkg::COEF_P), .in_y (item_a.a), .in_item (item_a),
      .out_valid (p_valid), .out_prod (p_prod), .out_item (p_item)
   );

   // ---- reciprocal chain, one quotient bit per cell
   logic               rc_valid [0:61];
   ecdf_pkg::item_type rc_item [0:61];

   always_comb begin
      rc_valid[0]    = p_valid;
      rc_item[0]     = p_item;
      rc_item[0].dvs = ecdf_pkg::ONE60 + p_prod[60 +: 64];
      rc_item[0].rem = ecdf_pkg::ONE60;
      rc_item[0].quo = '0;
   end

   for (genvar k = 0; k < 61; k++) begin : g_recip
      ecdf_recip_cell #(.FIRST(k == 0)) u_cell (
         .clock, .reset, .adv,
         .in_valid (rc_valid[k]), .in_item (rc_item[k]),
         .out_valid (rc_valid[k+1]), .out_item (rc_item[k+1])
      );
   end

   // ---- w = a^2 / 64
   logic               w_valid;
   logic [127:0]       w_prod;
   ecdf_pkg::item_type item_r, w_item;

   always_comb begin
      item_r   = rc_item[61];
      item_r.t = rc_item[61].quo;
   end

   ecdf_mul u_mul_w (
      .clock, .reset, .adv,
      .in_valid (rc_valid[61]), .in_x (item_r.a), .in_y (item_r.a), .in_item (item_r),
      .out_valid (w_valid), .out_prod (w_prod), .out_item (w_item)
   );

   // ---- exp(-w) by 24 Taylor terms
   logic               tc_valid [0:24];
   ecdf_pkg::item_type tc_item [0:24];

   always_comb begin
      tc_valid[0]     = w_valid;
      tc_item[0]      = w_item;
      tc_item[0].w    = {2'd0, w_prod[127:66]};
      tc_item[0].term = ecdf_pkg::ONE60;
      tc_item[0].sum  = ecdf_pkg::ONE60;
   end

   for (genvar k = 0; k < 24; k++) begin : g_taylor
      ecdf_taylor_cell #(.N(k + 1)) u_cell (
         .clock, .reset, .adv,
         .in_valid (tc_valid[k]), .in_item (tc_item[k]),
         .out_valid (tc_valid[k+1]), .out_item (tc_item[k+1])
      );
   end

   // ---- six squarings: exp(-z) = exp(-z/64)^64
   logic               sq_valid [0:6];
   ecdf_pkg::item_type sq_item [0:6];

   always_comb begin
      sq_valid[0]  = tc_valid[24];
      sq_item[0]   = tc_item[24];
      sq_item[0].e = ($signed(tc_item[24].sum) > 64'sd0) ? tc_item[24].sum : 64'd0;
   end

   for (genvar k = 0; k < 6; k++) begin : g_square
      logic               v_sq;
      logic [127:0]       p_sq;
      ecdf_pkg::item_type i_sq;

      ecdf_mul u_mul (
         .clock, .reset, .adv,
         .in_valid (sq_valid[k]), .in_x (sq_item[k].e), .in_y (sq_item[k].e),
         .in_item (sq_item[k]),
         .out_valid (v_sq), .out_prod (p_sq), .out_item (i_sq)
      );

      always_comb begin
         sq_valid[k+1]  = v_sq;
         sq_item[k+1]   = i_sq;
         sq_item[k+1].e = p_sq[60 +: 64];
      end
   end

   // ---- PDF value
   logic               pdf_valid;
   logic [127:0]       pdf_prod;
   ecdf_pkg::item_type pdf_item;

   ecdf_mul u_mul_pdf (
      .clock, .reset, .adv,
      .in_valid (sq_valid[6]), .in_x (ecdf_pkg::NORM_PDF_SCALE), .in_y (sq_item[6].e),
      .in_item (sq_item[6]),
      .out_valid (pdf_valid), .out_prod (pdf_prod), .out_item (pdf_item)
   );

   // ---- Horner polynomial in t, sign-magnitude multiplies
   logic               pl_valid [0:5];
   ecdf_pkg::item_type pl_item [0:5];

   always_comb begin
      pl_valid[0]    = pdf_valid;
      pl_item[0]     = pdf_item;
      pl_item[0].pdf = pdf_prod[60 +: 64];
      pl_item[0].acc = ecdf_pkg::COEF_A5;
   end

   for (genvar k = 0; k < 5; k++) begin : g_poly
      logic               v_pm, valid_ff;
      logic [127:0]       p_pm;
      ecdf_pkg::item_type feed, i_pm, item_ff, item_next;
      logic [63:0]        r;

      always_comb begin
         feed     = pl_item[k];
         feed.sgn = pl_item[k].acc[63];
      end

      ecdf_mul u_mul (
         .clock, .reset, .adv,
         .in_valid (pl_valid[k]),
         .in_x (feed.sgn ? 64'd0 - feed.acc : feed.acc), .in_y (feed.t),
         .in_item (feed),
         .out_valid (v_pm), .out_prod (p_pm), .out_item (i_pm)
      );

      always_comb begin
         r             = p_pm[60 +: 64];
         item_next     = i_pm;
         item_next.acc = (i_pm.sgn ? 64'd0 - r : r) + ecdf_pkg::POLY_ADD[k];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (adv) begin
            valid_ff <= v_pm;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            item_ff <= item_next;
         end
      end

      assign pl_valid[k+1] = valid_ff;
      assign pl_item[k+1]  = item_ff;
   end

   // ---- poly * exp, then final selection
   logic               f_valid;
   logic [127:0]       f_prod;
   ecdf_pkg::item_type f_item;
   logic [63:0]        acc_clamped;

   always_comb begin
      priority if ($signed(pl_item[5].acc) < 64'sd0) begin
         acc_clamped = 64'd0;
      end else if (pl_item[5].acc > ecdf_pkg::ONE60) begin
         acc_clamped = ecdf_pkg::ONE60;
      end else begin
         acc_clamped = pl_item[5].acc;
      end
   end

   ecdf_mul u_mul_f (
      .clock, .reset, .adv,
      .in_valid (pl_valid[5]), .in_x (acc_clamped), .in_y (pl_item[5].e),
      .in_item (pl_item[5]),
      .out_valid (f_valid), .out_prod (f_prod), .out_item (f_item)
   );

   logic [63:0] prod60, erfmag, c60;
   logic [31:0] erf_res, cdf_res, pdf_res, result_in;

   always_comb begin
      prod60  = f_prod[60 +: 64];
      if (prod60 > ecdf_pkg::ONE60) begin
         prod60 = ecdf_pkg::ONE60;
      end
      erfmag  = ecdf_pkg::ONE60 - prod60;
      erf_res = f_item.neg ? 32'd0 - round30(erfmag) : round30(erfmag);
      c60     = f_item.neg ? (ecdf_pkg::ONE60 - erfmag) >> 1
                           : (ecdf_pkg::ONE60 + erfmag) >> 1;
      cdf_res = round30(c60);
      pdf_res = round30(f_item.pdf);
      unique case (f_item.op)
         ecdf_pkg::OP_ERF: begin
            result_in = f_item.big ? (f_item.neg ? 32'd0 - ONE30 : ONE30) : erf_res;
         end
         ecdf_pkg::OP_CDF: begin
            result_in = f_item.big ? (f_item.neg ? 32'd0 : ONE30) : cdf_res;
         end
         ecdf_pkg::OP_PDF: begin
            result_in = f_item.big ? 32'd0 : pdf_res;
         end
         default: begin
            result_in = 32'd0;
         end
      endcase
   end

   // ---- output register
   logic            [31:0] result_ff;
   ecdf_pkg::op_type out_op_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= f_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         result_ff <= result_in;
         out_op_ff <= f_item.op;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.result_value = result_ff;

   // ---- checks
   `ECDF_ASSERT_IMPL(a_result_range, clock, reset, out_valid_ff, ($signed(result_ff) <= 32'sd1073741824) && ($signed(result_ff) >= -32'sd1073741824))
   `ECDF_ASSERT_IMPL(a_unused_op_zero, clock, reset, out_valid_ff && (out_op_ff == ecdf_pkg::OP_ZERO), result_ff == 32'd0)
   `ECDF_ASSERT_IMPL(a_cdf_nonneg, clock, reset, out_valid_ff && (out_op_ff == ecdf_pkg::OP_CDF), !result_ff[31])
   `ECDF_ASSERT_NEXT(a_accept_enters, clock, reset, req_ch.valid && req_ch.ready, v_in_ff)
endmodule

[sv/ecdf_mul.sv]
// Five-stage 64x64 multiplier: an input register, then one 32x32 partial product per stage.
module ecdf_mul (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  logic [63:0]        in_x,
   input  logic [63:0]        in_y,
   input  ecdf_pkg::item_type in_item,
   output logic               out_valid,
   output logic [127:0]       out_prod,
   output ecdf_pkg::item_type out_item
);
   logic [4:0]         valid_ff;
   logic [63:0]        x_ff [0:3];
   logic [63:0]        y_ff [0:3];
   ecdf_pkg::item_type item_ff [0:4];
   logic [127:0]       acc_ff [1:4];
   logic [127:0]       acc_in [1:4];
   logic [63:0]        pp [1:4];

   always_comb begin
      pp[1] = 64'(x_ff[0][31:0]) * 64'(y_ff[0][31:0]);
      pp[2] = 64'(x_ff[1][31:0]) * 64'(y_ff[1][63:32]);
      pp[3] = 64'(x_ff[2][63:32]) * 64'(y_ff[2][31:0]);
      pp[4] = 64'(x_ff[3][63:32]) * 64'(y_ff[3][63:32]);
      acc_in[1] = {64'd0, pp[1]};
      acc_in[2] = acc_ff[1] + {32'd0, pp[2], 32'd0};
      acc_in[3] = acc_ff[2] + {32'd0, pp[3], 32'd0};
      acc_in[4] = acc_ff[3] + {pp[4], 64'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   // hi halves still needed at stage 4, so x/y ride along in step with the sum
   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff[0]    <= in_x;
         y_ff[0]    <= in_y;
         x_ff[1]    <= x_ff[0];
         y_ff[1]    <= y_ff[0];
         x_ff[2]    <= x_ff[1];
         y_ff[2]    <= y_ff[1];
         x_ff[3]    <= x_ff[2];
         y_ff[3]    <= y_ff[2];
         item_ff[0] <= in_item;
         for (int s = 1; s < 5; s++) begin
            item_ff[s] <= item_ff[s-1];
         end
         acc_ff[1] <= acc_in[1];
         acc_ff[2] <= acc_in[2];
         acc_ff[3] <= acc_in[3];
         acc_ff[4] <= acc_in[4];
      end
   end

   assign out_valid = valid_ff[4];
   assign out_prod  = acc_ff[4];
   assign out_item  = item_ff[4];
endmodule

[sv/ecdf_recip_cell.sv]
// One restoring-division step of the reciprocal t = 1/d.
module ecdf_recip_cell #(
   parameter bit FIRST = 1'b0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  ecdf_pkg::item_type in_item,
   output logic               out_valid,
   output ecdf_pkg::item_type out_item
);
   logic               valid_ff;
   ecdf_pkg::item_type item_ff;
   ecdf_pkg::item_type item_in;
   logic [63:0]        r;
   logic [63:0]        q;

   always_comb begin
      item_in = in_item;
      r = FIRST ? in_item.rem : {in_item.rem[62:0], 1'b0};
      q = FIRST ? in_item.quo : {in_item.quo[62:0], 1'b0};
      if (r >= in_item.dvs) begin
         r = r - in_item.dvs;
         q = q | 64'd1;
      end
      item_in.rem = r;
      item_in.quo = q;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

[sv/ecdf_taylor_cell.sv]
// One Taylor term of exp(-w): term = term*w/N, then sum -= or += term.
module ecdf_taylor_cell #(
   parameter int unsigned N = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               adv,
   input  logic               in_valid,
   input  ecdf_pkg::item_type in_item,
   output logic               out_valid,
   output ecdf_pkg::item_type out_item
);
   // floor(2^64/N)-1 keeps the estimate at most one below the true quotient
   localparam logic [64:0] RECIP_WIDE = ((65'd1 << 64) / 65'(N)) - 65'd1;
   localparam logic [63:0] RECIP      = RECIP_WIDE[63:0];
   localparam logic [63:0] DIVISOR    = 64'(N);
   localparam bit          ODD        = (N % 2) == 1;

   logic               v1, v2;
   logic [127:0]       p1, p2;
   ecdf_pkg::item_type i1, i2, mid_item, item_in, item_ff;
   logic               valid_ff;
   logic [63:0]        q0, rest, quot;

   ecdf_mul u_term (
      .clock, .reset, .adv,
      .in_valid (in_valid), .in_x (in_item.term), .in_y (in_item.w), .in_item (in_item),
      .out_valid (v1), .out_prod (p1), .out_item (i1)
   );

   always_comb begin
      mid_item    = i1;
      mid_item.tv = p1[60 +: 64];
   end

   ecdf_mul u_recip (
      .clock, .reset, .adv,
      .in_valid (v1), .in_x (mid_item.tv), .in_y (RECIP), .in_item (mid_item),
      .out_valid (v2), .out_prod (p2), .out_item (i2)
   );

   always_comb begin
      q0      = p2[127:64];
      rest    = i2.tv - 64'(q0 * DIVISOR);
      quot    = (rest >= DIVISOR) ? q0 + 64'd1 : q0;
      item_in = i2;
      item_in.term = quot;
      item_in.sum  = ODD ? i2.sum - quot : i2.sum + quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= v2;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         item_ff <= item_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule

[tb/erf_normal_cdf_pdf_checker.sv]
// Checker for the erf / normal CDF / normal PDF block: predicts and compares results.
module erf_normal_cdf_pdf_checker #(
   parameter int X_FRAC_BITS = 16
) (
   input logic  clock,
   input logic  reset,
   ecdf_req_if  req_ch,
   ecdf_rsp_if  rsp_ch,
   output int   fail_count,
   output int   pending
);
   localparam logic [63:0] Q60_ONE = 64'd1 << 60;
   localparam logic [63:0] K_A1 = 64'((128'd254829592 << 60) / 128'd1000000000);
   localparam logic [63:0] K_A2 = 64'd0 - 64'((128'd284496736 << 60) / 128'd1000000000);
   localparam logic [63:0] K_A3 = 64'((128'd1421413741 << 60) / 128'd1000000000);
   localparam logic [63:0] K_A4 = 64'd0 - 64'((128'd1453152027 << 60) / 128'd1000000000);
   localparam logic [63:0] K_A5 = 64'((128'd1061405429 << 60) / 128'd1000000000);
   localparam logic [63:0] K_P = 64'((128'd3275911 << 60) / 128'd10000000);
   localparam logic [63:0] K_PDF = 64'((128'd3989422804 << 60) / 128'd10000000000);
   localparam logic [63:0] K_RT2 = 64'((128'd7071067812 << 60) / 128'd10000000000);

   logic [31:0] expected_values [$];

   function automatic logic [63:0] mulsh(logic [63:0] a, logic [63:0] b, int s);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return 64'(p >> s);
   endfunction

   function automatic logic signed [63:0] smul(logic signed [63:0] v, logic [63:0] t);
      logic [63:0] m;
      m = (v < 0) ? -v : v;
      m = mulsh(m, t, 60);
      return (v < 0) ? -$signed(m) : $signed(m);
   endfunction

   // exp(-64w) as exp(-w)^64
   function automatic logic [63:0] exp_of_neg(logic [63:0] w);
      logic signed [63:0] sum;
      logic [63:0] term;
      logic [63:0] e;
      sum = Q60_ONE;
      term = Q60_ONE;
      for (int n = 1; n <= 24; n++) begin
         term = mulsh(term, w, 60) / 64'(n);
         if (n % 2 == 1) sum = sum - $signed(term);
         else sum = sum + $signed(term);
      end
      e = (sum > 0) ? sum : 64'd0;
      for (int n = 0; n < 6; n++) e = mulsh(e, e, 60);
      return e;
   endfunction

   function automatic logic [63:0] rnd30(logic [63:0] v);
      return (v + (64'd1 << 29)) >> 30;
   endfunction

   function automatic logic [31:0] predict_value(ecdf_pkg::op_type op, logic [31:0] x);
      logic neg;
      logic [63:0] mag, lim, a, e, t, prod, erfm, res, c60;
      logic signed [63:0] acc;
      neg = x[31];
      mag = neg ? (64'h1_0000_0000 - {32'd0, x}) : {32'd0, x};
      lim = 64'(op == ecdf_pkg::OP_ERF ? 8 : 11) << X_FRAC_BITS;
      if (op == ecdf_pkg::OP_ZERO) return 32'd0;
      if (mag >= lim) begin
         if (op == ecdf_pkg::OP_ERF) return neg ? 32'hC000_0000 : 32'h4000_0000;
         if (op == ecdf_pkg::OP_CDF) return neg ? 32'd0 : 32'h4000_0000;
         return 32'd0;
      end
      if (op == ecdf_pkg::OP_ERF) a = mag << (60 - X_FRAC_BITS);
      else a = mulsh(mag, K_RT2, X_FRAC_BITS);
      e = exp_of_neg(mulsh(a, a, 66));
      if (op == ecdf_pkg::OP_PDF) return 32'(rnd30(mulsh(K_PDF, e, 60)));
      t = 64'((128'd1 << 120) / {64'd0, Q60_ONE + mulsh(K_P, a, 60)});
      acc = K_A5;
      acc = smul(acc, t) + $signed(K_A4);
      acc = smul(acc, t) + $signed(K_A3);
      acc = smul(acc, t) + $signed(K_A2);
      acc = smul(acc, t) + $signed(K_A1);
      acc = smul(acc, t);
      if (acc < 0) acc = 0;
      if (acc > $signed(Q60_ONE)) acc = Q60_ONE;
      prod = mulsh(acc, e, 60);
      if (prod > Q60_ONE) prod = Q60_ONE;
      erfm = Q60_ONE - prod;
      if (op == ecdf_pkg::OP_ERF) begin
         res = rnd30(erfm);
         if (neg) res = -res;
      end else begin
         c60 = neg ? (Q60_ONE - erfm) >> 1 : (Q60_ONE + erfm) >> 1;
         res = rnd30(c60);
      end
      return 32'(res);
   endfunction

   // sampled mid-cycle: what is stable here is what the next rising edge accepts
   always @(negedge clock) begin
      logic [31:0] want;
      if (reset) begin
         fail_count = 0;
         pending    = 0;
      end else begin
         if (req_ch.valid && req_ch.ready)
            expected_values.push_back(predict_value(ecdf_pkg::op_type'(req_ch.operation),
                                                    req_ch.x_value));
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_values.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result %h", rsp_ch.result_value);
            end else begin
               want = expected_values.pop_front();
               if (rsp_ch.result_value !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result_value mismatch: expected %h actual %h",
                              want, rsp_ch.result_value);
               end
            end
         end
         pending = expected_values.size();
      end
   end
endmodule

[tb/tb_erf_normal_cdf_pdf.sv]
// Testbench top for the erf / normal CDF / normal PDF block: stimulus and verdict.
module tb_erf_normal_cdf_pdf;
   localparam int XFB = 16;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_CYCLES = 450;   // pipeline is 412 deep

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending;
   int   cycles = 0;
   int   tx_idle_pct = 21;
   int   rx_idle_pct = 74;
   logic ready_seen;

   ecdf_req_if req_ch ();
   ecdf_rsp_if rsp_ch ();

   erf_normal_cdf_pdf #(.X_FRAC_BITS(XFB)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   erf_normal_cdf_pdf_checker #(.X_FRAC_BITS(XFB)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // receiver back-pressure follows the current idle percentage
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // ready as seen before the coming edge
   always @(negedge clock) ready_seen = req_ch.ready;

   // one transaction; valid stays high across back-to-back sends
   task automatic send_sample(ecdf_pkg::op_type op, logic [31:0] x);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.operation <= op;
      req_ch.x_value   <= x;
      do @(posedge clock); while (!ready_seen);
   endtask

   task automatic send_random(int count);
      ecdf_pkg::op_type op;
      logic [31:0] x;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(15) == 0) ? ecdf_pkg::OP_ZERO
                                        : ecdf_pkg::op_type'($urandom_range(2));
         case ($urandom_range(9))
            0: x = $urandom;                                        // full range
            1: x = 32'($signed($urandom_range(24 << XFB)) - (12 << XFB)); // limits
            2: x = 32'($signed($urandom_range(512)) - 256);         // near zero
            default: x = 32'($signed($urandom_range(16 << XFB)) - (8 << XFB));
         endcase
         send_sample(op, x);
      end
   endtask

   initial begin
      logic [31:0] edge_x [$];
      req_ch.valid     <= 1'b0;
      req_ch.operation <= ecdf_pkg::OP_ERF;
      req_ch.x_value   <= 32'd0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: zero, extremes, and both sides of each saturation threshold
      edge_x = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1,
                 32'(8 << XFB), 32'((8 << XFB) - 1), -32'(8 << XFB),
                 32'(11 << XFB), -32'((11 << XFB) - 1), 32'h0001_0000};
      foreach (edge_x[i]) send_sample(ecdf_pkg::op_type'(i % 3), edge_x[i]);
      for (int o = 0; o < 4; o++) begin
         send_sample(ecdf_pkg::op_type'(o), 32'h8000_0000);
         send_sample(ecdf_pkg::op_type'(o), 32'(11 << XFB) - 1);
      end
      send_sample(ecdf_pkg::OP_ZERO, 32'h7FFF_FFFF);

      send_random(620);
      tx_idle_pct = 74;
      rx_idle_pct = 21;
      send_random(620);
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      send_random(640);

      req_ch.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
